@@ sv/tsps_pkg.sv @@
// Shared constants, command codes and register map for the packet segmenter.
package tsps_pkg;

  localparam int PAYLOAD_BYTES = 1024;
  localparam int LENGTH_BITS   = 24;

  // Region lengths and positions keep the low bits of the 24-bit registers.
  localparam int LEN_W   = (LENGTH_BITS < 24) ? LENGTH_BITS : 24;
  localparam int ROOM_W  = $clog2(PAYLOAD_BYTES + 1);
  localparam int CMP_W   = (LEN_W > ROOM_W) ? LEN_W : ROOM_W;

  localparam int START_W = 24;
  localparam int COUNT_W = 14;
  localparam int FRAME_W = 64;
  localparam int PKT_W   = 16;
  localparam int TAG_W   = 16;

  localparam int ADDR_W  = 5;
  localparam int DATA_W  = 32;

  typedef enum logic [1:0] {
    FUNC_START = 2'd0,
    FUNC_NEXT  = 2'd1,
    FUNC_SET   = 2'd2
  } func_t;

  typedef enum logic [2:0] {
    REG_ANALOG_LEN      = 3'd0,
    REG_DIGITAL_LEN     = 3'd1,
    REG_TRANSCEIVER_LEN = 3'd2,
    REG_MODULE_NUMBER   = 3'd3,
    REG_DETECTOR_KIND   = 3'd4
  } reg_index_t;

endpackage

@@ sv/three_source_packet_segmenter_core.sv @@
// Packet segmenter core: cuts a three-region frame into fixed-size payload descriptors.
//
//  channel | direction | signals                                        | beat
//  --------+-----------+------------------------------------------------+--------------------
//  in      | sink      | in_valid, in_ready, func, frame_value          | one command
//  out     | source    | out_valid, out_ready, frame_done .. detector_tag | one descriptor
//  cfg     | APB slave | psel, penable, pwrite, paddr, pwdata, prdata, pready | one register
//
//  A command is held in the input register while three chained
//  compare-and-subtract steps build the descriptor into the result register.
//  A full result register stalls only packet requests; start and set commands pass.
//  Otherwise one command per cycle passes, and out_valid is set with each descriptor.
//  Synchronous reset clears all positions, counters and configuration.
module three_source_packet_segmenter_core
  import tsps_pkg::*;
(
  input  logic                 clk,
  input  logic                 rst,

  input  logic                 in_valid,
  output logic                 in_ready,
  input  logic [1:0]           func,
  input  logic [FRAME_W-1:0]   frame_value,

  output logic                 out_valid,
  input  logic                 out_ready,
  output logic                 frame_done,
  output logic [FRAME_W-1:0]   frame_number,
  output logic [PKT_W-1:0]     packet_number,
  output logic [START_W-1:0]   analog_start,
  output logic [COUNT_W-1:0]   analog_count,
  output logic [START_W-1:0]   digital_start,
  output logic [COUNT_W-1:0]   digital_count,
  output logic [START_W-1:0]   transceiver_start,
  output logic [COUNT_W-1:0]   transceiver_count,
  output logic [COUNT_W-1:0]   pad_count,
  output logic [TAG_W-1:0]     module_tag,
  output logic [TAG_W-1:0]     detector_tag,

  input  logic                 psel,
  input  logic                 penable,
  input  logic                 pwrite,
  input  logic [ADDR_W-1:0]    paddr,
  input  logic [DATA_W-1:0]    pwdata,
  output logic [DATA_W-1:0]    prdata,
  output logic                 pready
);

  typedef struct packed {
    logic [ROOM_W-1:0] n;
    logic [LEN_W-1:0]  pos;
    logic [ROOM_W-1:0] room;
  } take_t;

  function automatic take_t take_bytes(input logic [LEN_W-1:0]  pos,
                                       input logic [LEN_W-1:0]  len,
                                       input logic [ROOM_W-1:0] room);
    take_t             r;
    logic [LEN_W-1:0]  left;
    left   = len - pos;
    r.n    = '0;
    r.pos  = pos;
    r.room = room;
    if (pos < len) begin
      if (CMP_W'(left) < CMP_W'(room)) begin
        r.n = ROOM_W'(left);
      end else begin
        r.n = room;
      end
      r.pos  = pos + LEN_W'(r.n);
      r.room = room - r.n;
    end
    return r;
  endfunction

  // configuration
  logic [LEN_W-1:0]   analog_length;
  logic [LEN_W-1:0]   digital_length;
  logic [LEN_W-1:0]   transceiver_length;
  logic [TAG_W-1:0]   module_number;
  logic [TAG_W-1:0]   detector_kind;

  // segmenter state
  logic [LEN_W-1:0]   analog_position;
  logic [LEN_W-1:0]   digital_position;
  logic [LEN_W-1:0]   transceiver_position;
  logic [PKT_W-1:0]   packet_counter;
  logic [FRAME_W-1:0] frame_counter;

  // input register
  logic               s1_valid;
  logic [1:0]         s1_func;
  logic [FRAME_W-1:0] s1_frame_value;

  logic               s1_fire;
  logic               cfg_write;
  reg_index_t         cfg_index;

  logic               at_end;
  logic               at_start;
  logic [FRAME_W-1:0] frame_counter_next;
  logic [PKT_W-1:0]   packet_counter_next;
  take_t              take_a;
  take_t              take_d;
  take_t              take_t3;

  assign pready    = 1'b1;
  assign cfg_write = psel && penable && pwrite && pready;
  assign cfg_index = reg_index_t'(paddr[ADDR_W-1:2]);

  always_comb begin
    unique case (cfg_index)
      REG_ANALOG_LEN:      prdata = DATA_W'(analog_length);
      REG_DIGITAL_LEN:     prdata = DATA_W'(digital_length);
      REG_TRANSCEIVER_LEN: prdata = DATA_W'(transceiver_length);
      REG_MODULE_NUMBER:   prdata = DATA_W'(module_number);
      REG_DETECTOR_KIND:   prdata = DATA_W'(detector_kind);
      default:             prdata = '0;
    endcase
  end

  // A packet request needs a free result slot; other commands never wait.
  assign s1_fire  = s1_valid && ((s1_func != FUNC_NEXT) || !out_valid || out_ready);
  assign in_ready = !s1_valid || s1_fire;

  assign at_end   = (analog_position >= analog_length) &&
                    (digital_position >= digital_length) &&
                    (transceiver_position >= transceiver_length);
  assign at_start = (analog_position == '0) && (digital_position == '0) &&
                    (transceiver_position == '0);

  always_comb begin
    if (at_start) begin
      frame_counter_next  = frame_counter + FRAME_W'(1);
      packet_counter_next = '0;
    end else begin
      frame_counter_next  = frame_counter;
      packet_counter_next = packet_counter + PKT_W'(1);
    end
    take_a  = take_bytes(analog_position, analog_length, ROOM_W'(PAYLOAD_BYTES));
    take_d  = take_bytes(digital_position, digital_length, take_a.room);
    take_t3 = take_bytes(transceiver_position, transceiver_length, take_d.room);
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      analog_length        <= '0;
      digital_length       <= '0;
      transceiver_length   <= '0;
      module_number        <= '0;
      detector_kind        <= '0;
      analog_position      <= '0;
      digital_position     <= '0;
      transceiver_position <= '0;
      packet_counter       <= '0;
      frame_counter        <= '0;
      s1_valid             <= 1'b0;
      out_valid            <= 1'b0;
    end else begin
      if (cfg_write) begin
        unique case (cfg_index)
          REG_ANALOG_LEN:      analog_length      <= pwdata[LEN_W-1:0];
          REG_DIGITAL_LEN:     digital_length     <= pwdata[LEN_W-1:0];
          REG_TRANSCEIVER_LEN: transceiver_length <= pwdata[LEN_W-1:0];
          REG_MODULE_NUMBER:   module_number      <= pwdata[TAG_W-1:0];
          REG_DETECTOR_KIND:   detector_kind      <= pwdata[TAG_W-1:0];
          default: ;
        endcase
      end

      if (in_valid && in_ready) begin
        s1_valid       <= 1'b1;
        s1_func        <= func;
        s1_frame_value <= frame_value;
      end else if (s1_fire) begin
        s1_valid <= 1'b0;
      end

      if (s1_fire && (s1_func == FUNC_NEXT)) begin
        out_valid <= 1'b1;
      end else if (out_ready) begin
        out_valid <= 1'b0;
      end

      if (s1_fire) begin
        unique case (s1_func)
          FUNC_START: begin
            analog_position      <= '0;
            digital_position     <= '0;
            transceiver_position <= '0;
            frame_counter        <= '0;
          end
          FUNC_SET: begin
            // next frame start increments back to the requested value
            frame_counter <= s1_frame_value - FRAME_W'(1);
          end
          FUNC_NEXT: begin
            if (at_end) begin
              analog_position      <= '0;
              digital_position     <= '0;
              transceiver_position <= '0;
              frame_done           <= 1'b1;
              frame_number         <= '0;
              packet_number        <= '0;
              analog_start         <= '0;
              analog_count         <= '0;
              digital_start        <= '0;
              digital_count        <= '0;
              transceiver_start    <= '0;
              transceiver_count    <= '0;
              pad_count            <= '0;
              module_tag           <= '0;
              detector_tag         <= '0;
            end else begin
              analog_position      <= take_a.pos;
              digital_position     <= take_d.pos;
              transceiver_position <= take_t3.pos;
              frame_counter        <= frame_counter_next;
              packet_counter       <= packet_counter_next;
              frame_done           <= 1'b0;
              frame_number         <= frame_counter_next;
              packet_number        <= packet_counter_next;
              analog_start         <= START_W'(analog_position);
              analog_count         <= COUNT_W'(take_a.n);
              digital_start        <= START_W'(digital_position);
              digital_count        <= COUNT_W'(take_d.n);
              transceiver_start    <= START_W'(transceiver_position);
              transceiver_count    <= COUNT_W'(take_t3.n);
              pad_count            <= COUNT_W'(take_t3.room);
              module_tag           <= module_number;
              detector_tag         <= detector_kind;
            end
          end
          default: ;
        endcase
      end
    end
  end

endmodule

@@ sv/tsps_checker.sv @@
// Port-level checks for the packet segmenter core, bound into the core module.
module tsps_checker
  import tsps_pkg::*;
(
  input logic               clk,
  input logic               rst,
  input logic               out_valid,
  input logic               out_ready,
  input logic               frame_done,
  input logic [FRAME_W-1:0] frame_number,
  input logic [PKT_W-1:0]   packet_number,
  input logic [COUNT_W-1:0] analog_count,
  input logic [COUNT_W-1:0] digital_count,
  input logic [COUNT_W-1:0] transceiver_count,
  input logic [COUNT_W-1:0] pad_count,
  input logic               pready
);

  logic [COUNT_W+1:0] fill_sum;
  assign fill_sum = (COUNT_W+2)'(analog_count) + (COUNT_W+2)'(digital_count) +
                    (COUNT_W+2)'(transceiver_count) + (COUNT_W+2)'(pad_count);

  // hold a stalled descriptor
  a_out_hold: assert property (@(posedge clk) disable iff (rst)
    out_valid && !out_ready |=> out_valid && $stable(frame_number) &&
                                $stable(packet_number) && $stable(pad_count))
    else $error("stalled descriptor changed");

  a_reset_idle: assert property (@(posedge clk) rst |=> !out_valid)
    else $error("descriptor valid right after reset");

  // a data packet always fills the payload exactly
  a_payload_full: assert property (@(posedge clk) disable iff (rst)
    out_valid && !frame_done |-> fill_sum == (COUNT_W+2)'(PAYLOAD_BYTES))
    else $error("payload bytes do not add up");

  a_done_empty: assert property (@(posedge clk) disable iff (rst)
    out_valid && frame_done |-> fill_sum == '0 && packet_number == '0 &&
                                frame_number == '0)
    else $error("end-of-frame result carries data");

  a_pready: assert property (@(posedge clk) disable iff (rst) pready)
    else $error("pready dropped");

endmodule

bind three_source_packet_segmenter_core tsps_checker u_tsps_checker (
  .clk               (clk),
  .rst               (rst),
  .out_valid         (out_valid),
  .out_ready         (out_ready),
  .frame_done        (frame_done),
  .frame_number      (frame_number),
  .packet_number     (packet_number),
  .analog_count      (analog_count),
  .digital_count     (digital_count),
  .transceiver_count (transceiver_count),
  .pad_count         (pad_count),
  .pready            (pready)
);

@@ tb/sv/three_source_packet_segmenter_core_tb.sv @@
// Self-checking testbench for the three-source packet segmenter core.
`timescale 1ns / 100ps

module three_source_packet_segmenter_core_tb;
  import tsps_pkg::*;

  localparam logic [1:0] FUNC_UNUSED = 2'd3;
  localparam int QUIET_LIMIT = 4000;
  localparam int ITEMS_PER_MODE = 600;

  typedef struct packed {
    logic               done;
    logic [FRAME_W-1:0] frame;
    logic [PKT_W-1:0]   pkt;
    logic [START_W-1:0] a_start;
    logic [COUNT_W-1:0] a_cnt;
    logic [START_W-1:0] d_start;
    logic [COUNT_W-1:0] d_cnt;
    logic [START_W-1:0] t_start;
    logic [COUNT_W-1:0] t_cnt;
    logic [COUNT_W-1:0] pad;
    logic [TAG_W-1:0]   mod;
    logic [TAG_W-1:0]   det;
  } seg_desc_t;

  typedef struct packed {
    logic               is_reg;
    reg_index_t         idx;
    logic [DATA_W-1:0]  data;
    logic [1:0]         fn;
    logic [FRAME_W-1:0] fv;
    logic               typed;
    seg_desc_t          want;
  } stim_row_t;

  logic                 clk;
  logic                 rst;
  logic                 in_valid;
  logic                 in_ready;
  logic [1:0]           func;
  logic [FRAME_W-1:0]   frame_value;
  logic                 out_valid;
  logic                 out_ready;
  logic                 frame_done;
  logic [FRAME_W-1:0]   frame_number;
  logic [PKT_W-1:0]     packet_number;
  logic [START_W-1:0]   analog_start;
  logic [COUNT_W-1:0]   analog_count;
  logic [START_W-1:0]   digital_start;
  logic [COUNT_W-1:0]   digital_count;
  logic [START_W-1:0]   transceiver_start;
  logic [COUNT_W-1:0]   transceiver_count;
  logic [COUNT_W-1:0]   pad_count;
  logic [TAG_W-1:0]     module_tag;
  logic [TAG_W-1:0]     detector_tag;
  logic                 psel;
  logic                 penable;
  logic                 pwrite;
  logic [ADDR_W-1:0]    paddr;
  logic [DATA_W-1:0]    pwdata;
  logic [DATA_W-1:0]    prdata;
  logic                 pready;

  three_source_packet_segmenter_core uut (
    .clk(clk), .rst(rst),
    .in_valid(in_valid), .in_ready(in_ready), .func(func), .frame_value(frame_value),
    .out_valid(out_valid), .out_ready(out_ready), .frame_done(frame_done),
    .frame_number(frame_number), .packet_number(packet_number),
    .analog_start(analog_start), .analog_count(analog_count),
    .digital_start(digital_start), .digital_count(digital_count),
    .transceiver_start(transceiver_start), .transceiver_count(transceiver_count),
    .pad_count(pad_count), .module_tag(module_tag), .detector_tag(detector_tag),
    .psel(psel), .penable(penable), .pwrite(pwrite), .paddr(paddr),
    .pwdata(pwdata), .prdata(prdata), .pready(pready)
  );

  // segmenter state and register copies
  logic [START_W-1:0] len_a, len_d, len_t;
  logic [START_W-1:0] pos_a, pos_d, pos_t;
  logic [TAG_W-1:0]   module_id, detector_id;
  logic [PKT_W-1:0]   pkt_cnt;
  logic [FRAME_W-1:0] frame_cnt;

  seg_desc_t descs_due[$];
  stim_row_t directed_rows[$];
  seg_desc_t got_desc, want_desc;
  int errors = 0;
  int send_idle_pct = 0;
  int recv_stall_pct = 0;
  int hold_reqs = 0;
  int hold_seen = 0;
  int hold_left = 0;
  int quiet_cycles = 0;

  initial begin
    clk = 1'b0;
    forever #5 clk = ~clk;
  end

  function automatic int region_take(logic [START_W-1:0] pos, logic [START_W-1:0] len,
                                     int room);
    int left;
    if (pos >= len) return 0;
    left = int'(len - pos);
    return (left < room) ? left : room;
  endfunction

  task automatic segment_command(input logic [1:0] fn, input logic [FRAME_W-1:0] fv,
                                 output bit emits, output seg_desc_t d);
    int room;
    int n;
    emits = 1'b0;
    d = '0;
    case (fn)
      FUNC_START: begin
        pos_a = '0;
        pos_d = '0;
        pos_t = '0;
        frame_cnt = '0;
      end
      FUNC_SET: frame_cnt = fv - 64'd1;
      FUNC_NEXT: begin
        emits = 1'b1;
        if (pos_a >= len_a && pos_d >= len_d && pos_t >= len_t) begin
          pos_a = '0;
          pos_d = '0;
          pos_t = '0;
          d.done = 1'b1;
        end else begin
          if (pos_a == 0 && pos_d == 0 && pos_t == 0) begin
            frame_cnt = frame_cnt + 64'd1;
            pkt_cnt = '0;
          end else begin
            pkt_cnt = pkt_cnt + 16'd1;
          end
          d.frame = frame_cnt;
          d.pkt = pkt_cnt;
          // fill the payload region by region
          room = PAYLOAD_BYTES;
          d.a_start = pos_a;
          n = region_take(pos_a, len_a, room);
          d.a_cnt = COUNT_W'(n);
          pos_a = pos_a + START_W'(n);
          room = room - n;
          d.d_start = pos_d;
          n = region_take(pos_d, len_d, room);
          d.d_cnt = COUNT_W'(n);
          pos_d = pos_d + START_W'(n);
          room = room - n;
          d.t_start = pos_t;
          n = region_take(pos_t, len_t, room);
          d.t_cnt = COUNT_W'(n);
          pos_t = pos_t + START_W'(n);
          room = room - n;
          d.pad = COUNT_W'(room);
          d.mod = module_id;
          d.det = detector_id;
        end
      end
      default: ;
    endcase
  endtask

  task automatic reg_write(input reg_index_t idx, input logic [DATA_W-1:0] data);
    psel <= 1'b1;
    penable <= 1'b0;
    pwrite <= 1'b1;
    paddr <= ADDR_W'(int'(idx) * 4);
    pwdata <= data;
    @(posedge clk);
    penable <= 1'b1;
    do @(posedge clk); while (!pready);
    psel <= 1'b0;
    penable <= 1'b0;
    pwrite <= 1'b0;
    @(posedge clk);
    case (idx)
      REG_ANALOG_LEN:      len_a = data[START_W-1:0];
      REG_DIGITAL_LEN:     len_d = data[START_W-1:0];
      REG_TRANSCEIVER_LEN: len_t = data[START_W-1:0];
      REG_MODULE_NUMBER:   module_id = data[TAG_W-1:0];
      REG_DETECTOR_KIND:   detector_id = data[TAG_W-1:0];
      default: ;
    endcase
  endtask

  task automatic send_cmd(input logic [1:0] fn, input logic [FRAME_W-1:0] fv,
                          input bit typed, input seg_desc_t lit);
    bit emits;
    seg_desc_t d;
    while ($urandom_range(99) < send_idle_pct) begin
      in_valid <= 1'b0;
      @(posedge clk);
    end
    in_valid <= 1'b1;
    func <= fn;
    frame_value <= fv;
    do @(posedge clk); while (!in_ready);
    segment_command(fn, fv, emits, d);
    if (emits) descs_due.push_back(typed ? lit : d);
  endtask

  // wait for every descriptor, then let start/set commands drain the pipeline
  task automatic wait_idle();
    while (descs_due.size() != 0) @(posedge clk);
    repeat (4) @(posedge clk);
  endtask

  function automatic logic [DATA_W-1:0] rand_len();
    int r;
    r = $urandom_range(99);
    if (r < 15) return 0;
    if (r < 25) return $urandom_range(1, 64);
    if (r < 92) return $urandom_range(65, 3000);
    if (r < 96) return 32'h00FF_FFFF;
    return $urandom_range(0, 32'h00FF_FFFF);
  endfunction

  function void add_cmd(logic [1:0] fn, logic [FRAME_W-1:0] fv);
    stim_row_t r;
    r = '0;
    r.fn = fn;
    r.fv = fv;
    directed_rows.push_back(r);
  endfunction

  function void add_lit(logic [1:0] fn, seg_desc_t w);
    stim_row_t r;
    r = '0;
    r.fn = fn;
    r.typed = 1'b1;
    r.want = w;
    directed_rows.push_back(r);
  endfunction

  function void add_reg(reg_index_t idx, logic [DATA_W-1:0] data);
    stim_row_t r;
    r = '0;
    r.is_reg = 1'b1;
    r.idx = idx;
    r.data = data;
    directed_rows.push_back(r);
  endfunction

  function void cmp_field(string name, logic [63:0] want, logic [63:0] got);
    if (want !== got) begin
      $display("%0t: %s mismatch, expected %0h, actual %0h", $time, name, want, got);
      errors++;
    end
  endfunction

  // receiver: random stalls, or a long hold-off when asked
  always @(posedge clk) begin
    if (rst) begin
      out_ready <= 1'b0;
    end else begin
      if (hold_seen != hold_reqs) begin
        hold_seen = hold_reqs;
        hold_left = 256;
      end
      if (hold_left > 0) begin
        out_ready <= 1'b0;
        hold_left = hold_left - 1;
      end else begin
        out_ready <= ($urandom_range(99) >= recv_stall_pct);
      end
    end
  end

  always @(posedge clk) begin
    if (!rst && out_valid && out_ready) begin
      got_desc.done = frame_done;
      got_desc.frame = frame_number;
      got_desc.pkt = packet_number;
      got_desc.a_start = analog_start;
      got_desc.a_cnt = analog_count;
      got_desc.d_start = digital_start;
      got_desc.d_cnt = digital_count;
      got_desc.t_start = transceiver_start;
      got_desc.t_cnt = transceiver_count;
      got_desc.pad = pad_count;
      got_desc.mod = module_tag;
      got_desc.det = detector_tag;
      if (descs_due.size() == 0) begin
        $display("%0t: unexpected descriptor beat, expected none, actual %h", $time, got_desc);
        errors++;
      end else begin
        want_desc = descs_due.pop_front();
        cmp_field("frame_done", 64'(want_desc.done), 64'(got_desc.done));
        cmp_field("frame_number", want_desc.frame, got_desc.frame);
        cmp_field("packet_number", 64'(want_desc.pkt), 64'(got_desc.pkt));
        cmp_field("analog_start", 64'(want_desc.a_start), 64'(got_desc.a_start));
        cmp_field("analog_count", 64'(want_desc.a_cnt), 64'(got_desc.a_cnt));
        cmp_field("digital_start", 64'(want_desc.d_start), 64'(got_desc.d_start));
        cmp_field("digital_count", 64'(want_desc.d_cnt), 64'(got_desc.d_cnt));
        cmp_field("transceiver_start", 64'(want_desc.t_start), 64'(got_desc.t_start));
        cmp_field("transceiver_count", 64'(want_desc.t_cnt), 64'(got_desc.t_cnt));
        cmp_field("pad_count", 64'(want_desc.pad), 64'(got_desc.pad));
        cmp_field("module_tag", 64'(want_desc.mod), 64'(got_desc.mod));
        cmp_field("detector_tag", 64'(want_desc.det), 64'(got_desc.det));
      end
    end
  end

  always @(posedge clk) begin
    if (rst || (in_valid && in_ready) || (out_valid && out_ready)) begin
      quiet_cycles = 0;
    end else begin
      quiet_cycles = quiet_cycles + 1;
      if (quiet_cycles >= QUIET_LIMIT) begin
        $display("[three_source_packet_segmenter_core] ERROR");
        $finish;
      end
    end
  end

  initial begin : stimulus
    seg_desc_t lit;
    stim_row_t row;
    int sent;
    int seg_len;
    int pick;
    rst <= 1'b1;
    in_valid <= 1'b0;
    func <= FUNC_START;
    frame_value <= '0;
    psel <= 1'b0;
    penable <= 1'b0;
    pwrite <= 1'b0;
    paddr <= '0;
    pwdata <= '0;
    len_a = '0;
    len_d = '0;
    len_t = '0;
    pos_a = '0;
    pos_d = '0;
    pos_t = '0;
    module_id = '0;
    detector_id = '0;
    pkt_cnt = '0;
    frame_cnt = '0;

    // after reset every length is zero: end of frame
    lit = '0;
    lit.done = 1'b1;
    add_lit(FUNC_NEXT, lit);
    add_cmd(FUNC_UNUSED, 64'hFFFF_FFFF_FFFF_FFFF);
    add_reg(REG_ANALOG_LEN, 32'd1000);
    add_reg(REG_DIGITAL_LEN, 32'd30);
    add_reg(REG_TRANSCEIVER_LEN, 32'd5);
    add_reg(REG_MODULE_NUMBER, 32'hFFFF);
    add_reg(REG_DETECTOR_KIND, 32'h0);
    add_cmd(FUNC_NEXT, '0);
    add_cmd(FUNC_NEXT, '0);
    add_cmd(FUNC_NEXT, '0);
    // frame counter wraps to zero on the next frame start
    add_cmd(FUNC_SET, 64'h0);
    add_cmd(FUNC_NEXT, '0);
    add_cmd(FUNC_START, '0);
    add_cmd(FUNC_NEXT, '0);
    add_reg(REG_ANALOG_LEN, 32'h00FF_FFFF);
    add_reg(REG_DIGITAL_LEN, 32'h00FF_FFFF);
    add_reg(REG_TRANSCEIVER_LEN, 32'h00FF_FFFF);
    add_reg(REG_MODULE_NUMBER, 32'h0);
    add_reg(REG_DETECTOR_KIND, 32'hFFFF);
    add_cmd(FUNC_START, '0);
    add_cmd(FUNC_SET, 64'hFFFF_FFFF_FFFF_FFFF);
    lit = '0;
    lit.frame = 64'hFFFF_FFFF_FFFF_FFFF;
    lit.a_cnt = PAYLOAD_BYTES;
    lit.det = 16'hFFFF;
    add_lit(FUNC_NEXT, lit);
    add_cmd(FUNC_NEXT, '0);
    // shrink analog below its position mid-frame: skip it
    add_reg(REG_ANALOG_LEN, 32'd0);
    add_reg(REG_DIGITAL_LEN, 32'd2000);
    add_reg(REG_TRANSCEIVER_LEN, 32'd0);
    add_cmd(FUNC_NEXT, '0);
    add_cmd(FUNC_NEXT, '0);
    add_cmd(FUNC_NEXT, '0);
    add_reg(REG_DIGITAL_LEN, 32'd0);
    lit = '0;
    lit.done = 1'b1;
    add_lit(FUNC_NEXT, lit);
    add_lit(FUNC_NEXT, lit);
    add_reg(REG_ANALOG_LEN, 32'd1);
    add_reg(REG_TRANSCEIVER_LEN, 32'd1);
    add_reg(REG_MODULE_NUMBER, 32'h1234);
    add_reg(REG_DETECTOR_KIND, 32'h5678);
    add_cmd(FUNC_SET, 64'h5A5A_0F0F_C3C3_9669);
    add_cmd(FUNC_NEXT, '0);
    add_cmd(FUNC_NEXT, '0);
    add_cmd(FUNC_UNUSED, '0);
    add_cmd(FUNC_START, '0);
    add_cmd(FUNC_NEXT, '0);

    repeat (3) @(posedge clk);
    rst <= 1'b0;

    send_idle_pct = 11;
    recv_stall_pct = 45;
    foreach (directed_rows[i]) begin
      row = directed_rows[i];
      if (row.is_reg) begin
        in_valid <= 1'b0;
        wait_idle();
        reg_write(row.idx, row.data);
      end else begin
        send_cmd(row.fn, row.fv, row.typed, row.want);
      end
    end

    for (int mode = 0; mode < 3; mode++) begin
      case (mode)
        0: begin
          send_idle_pct = 11;
          recv_stall_pct = 45;
        end
        1: begin
          send_idle_pct = 45;
          recv_stall_pct = 11;
        end
        default: begin
          send_idle_pct = 0;
          recv_stall_pct = 0;
        end
      endcase
      sent = 0;
      while (sent < ITEMS_PER_MODE) begin
        // pause until every descriptor is back, then maybe reconfigure
        in_valid <= 1'b0;
        wait_idle();
        if ($urandom_range(9) != 0) begin
          if ($urandom_range(19) == 0) begin
            reg_write(REG_ANALOG_LEN, '0);
            reg_write(REG_DIGITAL_LEN, '0);
            reg_write(REG_TRANSCEIVER_LEN, '0);
          end else begin
            reg_write(REG_ANALOG_LEN, rand_len());
            reg_write(REG_DIGITAL_LEN, rand_len());
            reg_write(REG_TRANSCEIVER_LEN, rand_len());
          end
          reg_write(REG_MODULE_NUMBER, $urandom_range(0, 16'hFFFF));
          reg_write(REG_DETECTOR_KIND, $urandom_range(0, 16'hFFFF));
        end
        // long receiver hold-off: let the block back up into its input
        if (sent == 0) hold_reqs++;
        seg_len = $urandom_range(20, 80);
        for (int k = 0; k < seg_len; k++) begin
          pick = $urandom_range(99);
          if (pick < 86) begin
            send_cmd(FUNC_NEXT, {$urandom, $urandom}, 1'b0, '0);
            sent++;
          end else if (pick < 90) begin
            send_cmd(FUNC_START, {$urandom, $urandom}, 1'b0, '0);
            sent++;
          end else if (pick < 96) begin
            send_cmd(FUNC_SET, {$urandom, $urandom}, 1'b0, '0);
            sent++;
          end else begin
            send_cmd(FUNC_UNUSED, {$urandom, $urandom}, 1'b0, '0);
          end
        end
      end
    end

    in_valid <= 1'b0;
    while (descs_due.size() != 0) @(posedge clk);
    repeat (8) @(posedge clk);
    if (errors == 0) begin
      $display("[three_source_packet_segmenter_core] OK");
    end else begin
      $display("[three_source_packet_segmenter_core] ERROR");
    end
    $finish;
  end

endmodule
